// ===== sv/vb4_pkg.sv =====
package vb4_pkg;

  // Lane layout of the packed vectors
  localparam int COMP_BITS = 16;
  localparam int LANE_BITS = 16;
  localparam int VEC_BITS  = 4 * LANE_BITS;

  // Minor width: products of three lanes plus growth, signed
  localparam int MW = 52;

  // Normalizer widths
  localparam int UNIT_FRAC = 14;
  localparam int NRM_BITS  = 30;
  localparam int SQ_STEPS  = 32;
  localparam int QB        = 15;
  localparam int REM_BITS  = 46;

  // Squared-length floor for a usable cross product (length 0.001)
  localparam logic [43:0] TINY_LIMIT = 44'd1152921504606;

  typedef logic signed [LANE_BITS-1:0] lane_t;
  typedef lane_t [3:0] vec_t;
  typedef logic signed [MW-1:0] mval_t;
  typedef mval_t [3:0] mvec_t;

  // Fraction bits of the minors fed to the short-length check
  typedef enum logic [1:0] {
    FRAC_A,
    FRAC_B,
    FRAC_C
  } frac_sel_t;

  // Data riding alongside the arithmetic through every stage
  typedef struct packed {
    vec_t up;
    vec_t ov;
    vec_t d;
    vec_t a;
    vec_t b;
    logic deg;
  } side_t;

  // Sign-extended component of one lane
  function automatic lane_t lane_of(input logic [VEC_BITS-1:0] w, input logic [1:0] i);
    logic [LANE_BITS-1:0] raw;
    raw = w[i*LANE_BITS +: LANE_BITS];
    return lane_t'($signed(raw[COMP_BITS-1:0]));
  endfunction

endpackage

// ===== sv/view_basis_4d_core.sv =====
// Four-dimensional look-at view basis.
// Input channel in_*: one item carries eye point, target point, up and
// over vectors, each four signed Q7.8 lanes (x lowest). Result channel
// out_*: rows A, B, C, D as four signed Q1.14 lanes each, and a flag in
// out_tuser that marks a degenerate basis (all rows zero).
// The block is fully pipelined: a new item may enter every cycle while
// the output is not stalled. Each of the three normalizers has
// 55 stages: a short scaling front end, a 32-stage square root and a
// 15-stage divider; the three cross-product units have six stages each.
// When the receiver holds out_tready low with a result waiting, the
// whole pipeline freezes and in_tready drops; nothing is lost or
// repeated. A taken result frees the output register in the same cycle,
// so the input side keeps moving while the receiver keeps up.
// Synchronous reset clears every stage valid; the block accepts items in
// the first cycle after reset is released.
module view_basis_4d_core import vb4_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // eye_point[63:0], target_point[127:64], up_dir[191:128], over_dir[255:192]
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_a[63:0], row_b[127:64], row_c[191:128], row_d[255:192]
  output logic [255:0] out_tdata,
  // degenerate[0]
  output logic         out_tuser
);

  logic adv;

  // input stage: eye minus target
  logic  in_vld_r;
  mvec_t in_d_r, in_d_nxt;
  side_t in_side_r, in_side_nxt;

  logic  n0_vld, n1_vld, n2_vld;
  vec_t  n0_u, n1_u, n2_u;
  side_t n0_side, n1_side, n2_side;
  side_t side1, side2, side3;

  logic  x0_vld, x1_vld, x2_vld;
  mvec_t x0_m, x1_m, x2_m;
  side_t x0_side, x1_side, x2_side;

  logic         out_valid_r;
  logic [255:0] out_data_r, out_data_nxt;
  logic         out_deg_r;
  vec_t         c_row;

  // advance whenever the output register is free or being taken
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_comb begin
    lane_t e, t;
    logic  zero;
    zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      e = lane_of(in_tdata[63:0], 2'(i));
      t = lane_of(in_tdata[127:64], 2'(i));
      in_side_nxt.up[i] = lane_of(in_tdata[191:128], 2'(i));
      in_side_nxt.ov[i] = lane_of(in_tdata[255:192], 2'(i));
      in_d_nxt[i] = mval_t'(e) - mval_t'(t);
      if (in_d_nxt[i] != '0) begin
        zero = 1'b0;
      end
    end
    in_side_nxt.d   = '0;
    in_side_nxt.a   = '0;
    in_side_nxt.b   = '0;
    in_side_nxt.deg = zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_d_r    <= in_d_nxt;
      in_side_r <= in_side_nxt;
    end
  end

  // D = unit(eye - target)
  vb4_norm u_norm_d (
    .clk, .rst_n, .adv,
    .in_vld   (in_vld_r),
    .v        (in_d_r),
    .side_in  (in_side_r),
    .out_vld  (n0_vld),
    .u        (n0_u),
    .side_out (n0_side)
  );

  always_comb begin
    side1   = n0_side;
    side1.d = n0_u;
  end

  vb4_cross u_cross_a (
    .clk, .rst_n, .adv,
    .in_vld   (n0_vld),
    .frac     (FRAC_A),
    .p        (side1.up),
    .q        (side1.ov),
    .s        (side1.d),
    .side_in  (side1),
    .out_vld  (x0_vld),
    .m_out    (x0_m),
    .side_out (x0_side)
  );

  vb4_norm u_norm_a (
    .clk, .rst_n, .adv,
    .in_vld   (x0_vld),
    .v        (x0_m),
    .side_in  (x0_side),
    .out_vld  (n1_vld),
    .u        (n1_u),
    .side_out (n1_side)
  );

  always_comb begin
    side2   = n1_side;
    side2.a = n1_u;
  end

  vb4_cross u_cross_b (
    .clk, .rst_n, .adv,
    .in_vld   (n1_vld),
    .frac     (FRAC_B),
    .p        (side2.ov),
    .q        (side2.d),
    .s        (side2.a),
    .side_in  (side2),
    .out_vld  (x1_vld),
    .m_out    (x1_m),
    .side_out (x1_side)
  );

  vb4_norm u_norm_b (
    .clk, .rst_n, .adv,
    .in_vld   (x1_vld),
    .v        (x1_m),
    .side_in  (x1_side),
    .out_vld  (n2_vld),
    .u        (n2_u),
    .side_out (n2_side)
  );

  always_comb begin
    side3   = n2_side;
    side3.b = n2_u;
  end

  vb4_cross u_cross_c (
    .clk, .rst_n, .adv,
    .in_vld   (n2_vld),
    .frac     (FRAC_C),
    .p        (side3.d),
    .q        (side3.a),
    .s        (side3.b),
    .side_in  (side3),
    .out_vld  (x2_vld),
    .m_out    (x2_m),
    .side_out (x2_side)
  );

  // C: minor / 2^28, half away from zero, saturated to 16 bits
  always_comb begin
    logic [MW-1:0] mag;
    logic [MW-1:0] qv;
    for (int i = 0; i < 4; i++) begin
      mag = x2_m[i][MW-1] ? -x2_m[i] : x2_m[i];
      qv  = (mag + (MW'(1) << 27)) >> 28;
      if (x2_m[i][MW-1]) begin
        if (qv > MW'(32768)) begin
          qv = MW'(32768);
        end
        c_row[i] = -lane_t'(qv[15:0]);
      end else begin
        if (qv > MW'(32767)) begin
          qv = MW'(32767);
        end
        c_row[i] = lane_t'(qv[15:0]);
      end
    end
    if (x2_side.deg) begin
      out_data_nxt = '0;
    end else begin
      out_data_nxt = {x2_side.d, c_row, x2_side.b, x2_side.a};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= x2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_deg_r  <= x2_side.deg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_deg_r;

  // D lanes of a formed basis never exceed unit magnitude
  logic d_in_range;
  always_comb begin
    d_in_range = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ($signed(out_tdata[192 + 16*i +: 16]) > 16'sd16384 ||
          $signed(out_tdata[192 + 16*i +: 16]) < -16'sd16384) begin
        d_in_range = 1'b0;
      end
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero rows");

  a_d_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> d_in_range)
    else $error("row D lane beyond unit magnitude");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(in_vld_r) && $stable(x2_vld) && $stable(n0_vld))
    else $error("pipeline moved while output stalled");

endmodule

// ===== sv/vb4_cross.sv =====
module vb4_cross import vb4_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_vld,
  input  frac_sel_t frac,
  input  vec_t      p,
  input  vec_t      q,
  input  vec_t      s,
  input  side_t     side_in,
  output logic      out_vld,
  output mvec_t     m_out,
  output side_t     side_out
);

  logic [5:0] vld_r;

  // stage 1: 2x2 minors of q, s; pairs 01,02,03,12,13,23
  logic signed [32:0] s1_m2_r [6];
  logic signed [32:0] s1_m2_nxt [6];
  vec_t  s1_p_r;
  side_t s1_side_r;

  // stage 2: lane times 2x2 minor
  logic signed [48:0] s2_pr_r [4][3];
  logic signed [48:0] s2_pr_nxt [4][3];
  side_t s2_side_r;

  // stage 3: 3x3 minors with cofactor signs
  mvec_t s3_m_r, s3_m_nxt;
  side_t s3_side_r;

  // stage 4: magnitudes trimmed to 30 fraction bits
  logic [20:0] s4_t_r [4];
  logic [20:0] s4_t_nxt [4];
  logic        s4_big_r, s4_big_nxt;
  mvec_t       s4_m_r;
  side_t       s4_side_r;

  // stage 5: squares
  logic [41:0] s5_sq_r [4];
  logic        s5_big_r;
  mvec_t       s5_m_r;
  side_t       s5_side_r;

  // stage 6: length test
  logic [43:0] sum_nxt;
  logic        tiny_nxt;
  mvec_t       s6_m_r;
  side_t       s6_side_r, s6_side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_comb begin
    s1_m2_nxt[0] = q[0] * s[1] - q[1] * s[0];
    s1_m2_nxt[1] = q[0] * s[2] - q[2] * s[0];
    s1_m2_nxt[2] = q[0] * s[3] - q[3] * s[0];
    s1_m2_nxt[3] = q[1] * s[2] - q[2] * s[1];
    s1_m2_nxt[4] = q[1] * s[3] - q[3] * s[1];
    s1_m2_nxt[5] = q[2] * s[3] - q[3] * s[2];
  end

  always_comb begin
    s2_pr_nxt[0][0] = s1_p_r[1] * s1_m2_r[5];
    s2_pr_nxt[0][1] = s1_p_r[2] * s1_m2_r[4];
    s2_pr_nxt[0][2] = s1_p_r[3] * s1_m2_r[3];
    s2_pr_nxt[1][0] = s1_p_r[0] * s1_m2_r[5];
    s2_pr_nxt[1][1] = s1_p_r[2] * s1_m2_r[2];
    s2_pr_nxt[1][2] = s1_p_r[3] * s1_m2_r[1];
    s2_pr_nxt[2][0] = s1_p_r[0] * s1_m2_r[4];
    s2_pr_nxt[2][1] = s1_p_r[1] * s1_m2_r[2];
    s2_pr_nxt[2][2] = s1_p_r[3] * s1_m2_r[0];
    s2_pr_nxt[3][0] = s1_p_r[0] * s1_m2_r[3];
    s2_pr_nxt[3][1] = s1_p_r[1] * s1_m2_r[1];
    s2_pr_nxt[3][2] = s1_p_r[2] * s1_m2_r[0];
  end

  // odd components of the 4D cross product are negated
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s3_m_nxt[k] = mval_t'(s2_pr_r[k][0]) - mval_t'(s2_pr_r[k][1])
                  + mval_t'(s2_pr_r[k][2]);
      if (k[0]) begin
        s3_m_nxt[k] = -s3_m_nxt[k];
      end
    end
  end

  always_comb begin
    logic [MW-1:0] mag;
    logic [3:0]    sh;
    case (frac)
      FRAC_A:  sh = 4'd0;
      FRAC_B:  sh = 4'd6;
      FRAC_C:  sh = 4'd12;
      default: sh = 4'd0;
    endcase
    s4_big_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      mag = s3_m_r[i][MW-1] ? -s3_m_r[i] : s3_m_r[i];
      if ((mag >> (6'd21 + 6'(sh))) != '0) begin
        s4_big_nxt = 1'b1;
      end
      s4_t_nxt[i] = 21'(mag >> sh);
    end
  end

  assign sum_nxt = 44'(s5_sq_r[0]) + 44'(s5_sq_r[1]) + 44'(s5_sq_r[2]) + 44'(s5_sq_r[3]);
  assign tiny_nxt = !s5_big_r && (sum_nxt <= TINY_LIMIT);

  // a short cross product marks the item degenerate
  always_comb begin
    s6_side_nxt     = s5_side_r;
    s6_side_nxt.deg = s5_side_r.deg | tiny_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_m2_r   <= s1_m2_nxt;
      s1_p_r    <= p;
      s1_side_r <= side_in;
      s2_pr_r   <= s2_pr_nxt;
      s2_side_r <= s1_side_r;
      s3_m_r    <= s3_m_nxt;
      s3_side_r <= s2_side_r;
      s4_t_r    <= s4_t_nxt;
      s4_big_r  <= s4_big_nxt;
      s4_m_r    <= s3_m_r;
      s4_side_r <= s3_side_r;
      for (int i = 0; i < 4; i++) begin
        s5_sq_r[i] <= s4_t_r[i] * s4_t_r[i];
      end
      s5_big_r  <= s4_big_r;
      s5_m_r    <= s4_m_r;
      s5_side_r <= s4_side_r;
      s6_m_r    <= s5_m_r;
      s6_side_r <= s6_side_nxt;
    end
  end

  assign out_vld  = vld_r[5];
  assign m_out    = s6_m_r;
  assign side_out = s6_side_r;

endmodule

// ===== sv/vb4_norm.sv =====
module vb4_norm import vb4_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_vld,
  input  mvec_t v,
  input  side_t side_in,
  output logic  out_vld,
  output vec_t  u,
  output side_t side_out
);

  // front stages: magnitude, leading-one search, scale, square
  logic [4:0] fv_r;

  logic [MW-1:0] s1_a_r [4];
  logic [MW-1:0] s1_a_nxt [4];
  logic [3:0]    s1_neg_r;
  logic [MW-1:0] s1_or_r, s1_or_nxt;
  side_t         s1_side_r;

  logic [MW-1:0] s2_a_r [4];
  logic [3:0]    s2_neg_r;
  logic [6:0]    s2_nz_r, s2_nz_nxt;
  logic [2:0]    s2_pos_r [7];
  logic [2:0]    s2_pos_nxt [7];
  side_t         s2_side_r;

  logic [MW-1:0] s3_a_r [4];
  logic [3:0]    s3_neg_r;
  logic [5:0]    s3_pos_r, s3_pos_nxt;
  side_t         s3_side_r;

  logic [NRM_BITS-1:0] s4_a_r [4];
  logic [NRM_BITS-1:0] s4_a_nxt [4];
  logic [3:0]          s4_neg_r;
  side_t               s4_side_r;

  logic [2*NRM_BITS-1:0] s5_sq_r [4];
  logic [NRM_BITS-1:0]   s5_a_r [4];
  logic [3:0]            s5_neg_r;
  side_t                 s5_side_r;

  // square root, one result bit per stage
  logic [SQ_STEPS:0]   sq_vld_r;
  logic [63:0]         sq_x_r [SQ_STEPS+1];
  logic [63:0]         sq_res_r [SQ_STEPS+1];
  logic [NRM_BITS-1:0] sq_a_r [SQ_STEPS+1][4];
  logic [3:0]          sq_neg_r [SQ_STEPS+1];
  side_t               sq_side_r [SQ_STEPS+1];

  // restoring divide, one quotient bit per stage
  logic [QB:0]         dv_vld_r;
  logic [REM_BITS-1:0] dv_rem_r [QB+1][4];
  logic [QB-1:0]       dv_q_r [QB+1][4];
  logic [31:0]         dv_r_r [QB+1];
  logic [3:0]          dv_neg_r [QB+1];
  side_t               dv_side_r [QB+1];

  logic  out_vld_r;
  vec_t  u_r, u_nxt;
  side_t side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r        <= '0;
      sq_vld_r[0] <= 1'b0;
      dv_vld_r[0] <= 1'b0;
      out_vld_r   <= 1'b0;
    end else if (adv) begin
      fv_r        <= {fv_r[3:0], in_vld};
      sq_vld_r[0] <= fv_r[4];
      dv_vld_r[0] <= sq_vld_r[SQ_STEPS];
      out_vld_r   <= dv_vld_r[QB];
    end
  end

  always_comb begin
    s1_or_nxt = '0;
    for (int i = 0; i < 4; i++) begin
      s1_a_nxt[i] = v[i][MW-1] ? -v[i] : v[i];
      s1_or_nxt   = s1_or_nxt | s1_a_nxt[i];
    end
  end

  // msb position within each byte of the OR of all magnitudes
  always_comb begin
    logic [55:0] orp;
    orp = 56'(s1_or_r);
    for (int g = 0; g < 7; g++) begin
      s2_nz_nxt[g]  = orp[g*8 +: 8] != 8'd0;
      s2_pos_nxt[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (orp[g*8+b]) begin
          s2_pos_nxt[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    s3_pos_nxt = 6'd0;
    for (int g = 0; g < 7; g++) begin
      if (s2_nz_r[g]) begin
        s3_pos_nxt = {3'(g), s2_pos_r[g]};
      end
    end
  end

  // bring the largest magnitude into [2^29, 2^30)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (s3_pos_r >= 6'd29) begin
        s4_a_nxt[i] = NRM_BITS'(s3_a_r[i] >> (s3_pos_r - 6'd29));
      end else begin
        s4_a_nxt[i] = NRM_BITS'(s3_a_r[i] << (6'd29 - s3_pos_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r    <= s1_a_nxt;
      s1_or_r   <= s1_or_nxt;
      for (int i = 0; i < 4; i++) begin
        s1_neg_r[i] <= v[i][MW-1];
      end
      s1_side_r <= side_in;
      s2_a_r    <= s1_a_r;
      s2_neg_r  <= s1_neg_r;
      s2_nz_r   <= s2_nz_nxt;
      s2_pos_r  <= s2_pos_nxt;
      s2_side_r <= s1_side_r;
      s3_a_r    <= s2_a_r;
      s3_neg_r  <= s2_neg_r;
      s3_pos_r  <= s3_pos_nxt;
      s3_side_r <= s2_side_r;
      s4_a_r    <= s4_a_nxt;
      s4_neg_r  <= s3_neg_r;
      s4_side_r <= s3_side_r;
      for (int i = 0; i < 4; i++) begin
        s5_sq_r[i] <= s4_a_r[i] * s4_a_r[i];
      end
      s5_a_r    <= s4_a_r;
      s5_neg_r  <= s4_neg_r;
      s5_side_r <= s4_side_r;
      // sum of squares enters the root pipeline
      sq_x_r[0]    <= 64'(s5_sq_r[0]) + 64'(s5_sq_r[1]) + 64'(s5_sq_r[2])
                    + 64'(s5_sq_r[3]);
      sq_res_r[0]  <= 64'd0;
      sq_a_r[0]    <= s5_a_r;
      sq_neg_r[0]  <= s5_neg_r;
      sq_side_r[0] <= s5_side_r;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [63:0] bitv, trial, x_nxt, res_nxt;

    always_comb begin
      bitv  = 64'd1 << (62 - 2*k);
      trial = sq_res_r[k] + bitv;
      if (sq_x_r[k] >= trial) begin
        x_nxt   = sq_x_r[k] - trial;
        res_nxt = (sq_res_r[k] >> 1) + bitv;
      end else begin
        x_nxt   = sq_x_r[k];
        res_nxt = sq_res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_x_r[k+1]    <= x_nxt;
        sq_res_r[k+1]  <= res_nxt;
        sq_a_r[k+1]    <= sq_a_r[k];
        sq_neg_r[k+1]  <= sq_neg_r[k];
        sq_side_r[k+1] <= sq_side_r[k];
      end
    end
  end

  // numerator |a| * 2^14 + r/2 for round half up
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r_r[0] <= 32'(sq_res_r[SQ_STEPS]);
      for (int i = 0; i < 4; i++) begin
        dv_rem_r[0][i] <= (REM_BITS'(sq_a_r[SQ_STEPS][i]) << UNIT_FRAC)
                        + REM_BITS'(sq_res_r[SQ_STEPS][31:1]);
        dv_q_r[0][i]   <= '0;
      end
      dv_neg_r[0]  <= sq_neg_r[SQ_STEPS];
      dv_side_r[0] <= sq_side_r[SQ_STEPS];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [REM_BITS-1:0] dvs;
    logic [REM_BITS-1:0] rem_nxt [4];
    logic [QB-1:0]       q_nxt [4];

    always_comb begin
      dvs = REM_BITS'(dv_r_r[k]) << (QB - 1 - k);
      for (int i = 0; i < 4; i++) begin
        if (dv_rem_r[k][i] >= dvs) begin
          rem_nxt[i] = dv_rem_r[k][i] - dvs;
          q_nxt[i]   = {dv_q_r[k][i][QB-2:0], 1'b1};
        end else begin
          rem_nxt[i] = dv_rem_r[k][i];
          q_nxt[i]   = {dv_q_r[k][i][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[k+1]  <= rem_nxt;
        dv_q_r[k+1]    <= q_nxt;
        dv_r_r[k+1]    <= dv_r_r[k];
        dv_neg_r[k+1]  <= dv_neg_r[k];
        dv_side_r[k+1] <= dv_side_r[k];
      end
    end
  end

  // restore signs
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      u_nxt[i] = dv_neg_r[QB][i] ? -lane_t'(dv_q_r[QB][i]) : lane_t'(dv_q_r[QB][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r    <= u_nxt;
      side_r <= dv_side_r[QB];
    end
  end

  assign out_vld  = out_vld_r;
  assign u        = u_r;
  assign side_out = side_r;

endmodule
